// ===== rtl/core/rau_pkg.sv =====
// rau_pkg: shared types, function codes and sequencer states for the rational unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_NEG  = 3'd4,
    FN_CMP  = 3'd5,
    FN_NORM = 3'd6,
    FN_NOP  = 3'd7
  } func_t;

  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_ZERO_DEN = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         cmp_code;
    logic               status;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN,
    S_GCD,
    S_DIVN_INIT,
    S_DIVN,
    S_DIVD_INIT,
    S_DIVD,
    S_DONE
  } state_t;

  // shared multiplier operand pair
  typedef struct packed {
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] y;
  } mul_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/rau_div.sv =====
// rau_div: restoring divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [rau_pkg::WORD_BITS-1:0] dividend,
  input  wire logic [rau_pkg::WORD_BITS-1:0] divisor,
  output logic                               done,
  output logic [rau_pkg::WORD_BITS-1:0]      quotient
);
  localparam int W  = rau_pkg::WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // one restoring step
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    shifted = {rem_r[W-1:0], q_r[W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (load) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = run_r && (cnt_r == CW'(1));
  assign quotient = q_nxt;
endmodule
`default_nettype wire

// ===== rtl/core/rational_arith_unit_core.sv =====
// rational_arith_unit_core: top level, sequencer around one shared multiplier,
// a binary gcd step unit and one shared restoring divider
// depends on rau_pkg, rau_div
//
//  channel | ports                 | handshake
//  --------+-----------------------+------------------------------
//  request | in_req, start, busy   | taken when start && !busy
//  result  | out_res, out_valid    | one cycle strobe, no stall
//
// add, sub, mul, div, negate, compare: S_MUL0 to S_MUL3 make four passes through
// the one 32x32 multiplier, then S_FIN does the final add/compare and S_DONE strobes
// the result; normalize: binary gcd steps, then two divisions on the shared divider
// (numerator, then denominator); zero numerator or zero denominator skip both
// reset clears the sequencer; busy stays high until the result strobe
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire rau_pkg::in_req_t in_req,
  output logic                  out_valid,
  output rau_pkg::out_res_t     out_res
);
  localparam int W = rau_pkg::WORD_BITS;

  rau_pkg::state_t  state_r, state_nxt;
  rau_pkg::in_req_t req_r;
  rau_pkg::out_res_t res_r, res_nxt;
  logic              valid_r, valid_nxt;

  // product registers
  logic signed [2*W-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [2*W-1:0] prod;
  rau_pkg::mul_op_t      mop;

  // gcd working registers
  logic [W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [W-1:0] n_mag_r, d_mag_r, qn_r, qn_nxt;
  logic [$clog2(W+1)-1:0] sh_r, sh_nxt;
  logic [W-1:0] g_full;

  logic signed [W-1:0] an, ad, bn, bd;
  logic                div_load, div_done;
  logic [W-1:0]        div_a, div_b, div_q;
  logic                neg;

  assign an = req_r.a_num[W-1:0];
  assign ad = req_r.a_den[W-1:0];
  assign bn = req_r.b_num[W-1:0];
  assign bd = req_r.b_den[W-1:0];
  assign neg = an[W-1] ^ ad[W-1];
  assign g_full = gx_r << sh_r;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      rau_pkg::S_MUL0: mop = '{x: an, y: bd};
      rau_pkg::S_MUL1: mop = '{x: ad, y: bn};
      rau_pkg::S_MUL2: mop = '{x: an, y: bn};
      rau_pkg::S_MUL3: mop = '{x: ad, y: bd};
      default:         mop = '{x: an, y: bd};
    endcase
  end
  assign prod = mop.x * mop.y;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    logic [W-1:0] num_c, den_c, dif;
    state_nxt = state_r;
    res_nxt   = res_r;
    valid_nxt = 1'b0;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    sh_nxt    = sh_r;
    qn_nxt    = qn_r;
    div_load  = 1'b0;
    div_a     = n_mag_r;
    div_b     = g_full;
    num_c     = '0;
    den_c     = '0;
    dif       = '0;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: state_nxt = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3: state_nxt = rau_pkg::S_FIN;
      rau_pkg::S_FIN: begin
        res_nxt   = '0;
        state_nxt = rau_pkg::S_DONE;
        case (rau_pkg::func_t'(req_r.func))
          rau_pkg::FN_ADD: begin
            num_c = p0_r[W-1:0] + p1_r[W-1:0];
            den_c = p3_r[W-1:0];
          end
          rau_pkg::FN_SUB: begin
            num_c = p0_r[W-1:0] - p1_r[W-1:0];
            den_c = p3_r[W-1:0];
          end
          rau_pkg::FN_MUL: begin
            num_c = p2_r[W-1:0];
            den_c = p3_r[W-1:0];
          end
          rau_pkg::FN_DIV: begin
            num_c = p0_r[W-1:0];
            den_c = p1_r[W-1:0];
          end
          rau_pkg::FN_NEG: begin
            num_c = -an;
            den_c = ad;
          end
          rau_pkg::FN_CMP: begin
            if (p0_r < p1_r) begin
              res_nxt.cmp_code = rau_pkg::CMP_LESS;
            end else if (p0_r == p1_r) begin
              res_nxt.cmp_code = rau_pkg::CMP_EQUAL;
            end else begin
              res_nxt.cmp_code = rau_pkg::CMP_GREATER;
            end
          end
          rau_pkg::FN_NORM: begin
            if (ad == '0) begin
              num_c = an;
              den_c = ad;
              res_nxt.status = rau_pkg::ST_ZERO_DEN;
            end else if (an == '0) begin
              den_c = W'(1);
            end else begin
              gx_nxt    = n_mag_r;
              gy_nxt    = d_mag_r;
              sh_nxt    = '0;
              state_nxt = rau_pkg::S_GCD;
            end
          end
          default: ;
        endcase
        res_nxt.res_num = 32'(signed'(num_c));
        res_nxt.res_den = 32'(signed'(den_c));
      end
      // binary gcd: one step per cycle
      rau_pkg::S_GCD: begin
        if (gx_r == gy_r) begin
          state_nxt = rau_pkg::S_DIVN_INIT;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          sh_nxt = sh_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_r > gy_r) begin
          dif    = gx_r - gy_r;
          gx_nxt = dif >> 1;
        end else begin
          dif    = gy_r - gx_r;
          gy_nxt = dif >> 1;
        end
      end
      rau_pkg::S_DIVN_INIT: begin
        div_load  = 1'b1;
        state_nxt = rau_pkg::S_DIVN;
      end
      rau_pkg::S_DIVN: begin
        if (div_done) begin
          qn_nxt    = div_q;
          state_nxt = rau_pkg::S_DIVD_INIT;
        end
      end
      rau_pkg::S_DIVD_INIT: begin
        div_load  = 1'b1;
        div_a     = d_mag_r;
        state_nxt = rau_pkg::S_DIVD;
      end
      rau_pkg::S_DIVD: begin
        div_a = d_mag_r;
        if (div_done) begin
          res_nxt          = '0;
          num_c            = neg ? -qn_r : qn_r;
          res_nxt.res_num  = 32'(signed'(num_c));
          res_nxt.res_den  = 32'(signed'(div_q));
          state_nxt        = rau_pkg::S_DONE;
        end
      end
      rau_pkg::S_DONE: begin
        valid_nxt = 1'b1;
        state_nxt = rau_pkg::S_IDLE;
      end
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // state, request, product and working register capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    if (state_r == rau_pkg::S_IDLE && start) begin
      req_r <= in_req;
    end
    if (state_r == rau_pkg::S_MUL0) begin
      p0_r    <= prod;
      n_mag_r <= an[W-1] ? W'(-an) : W'(an);
      d_mag_r <= ad[W-1] ? W'(-ad) : W'(ad);
    end
    if (state_r == rau_pkg::S_MUL1) p1_r <= prod;
    if (state_r == rau_pkg::S_MUL2) p2_r <= prod;
    if (state_r == rau_pkg::S_MUL3) p3_r <= prod;
    res_r <= res_nxt;
    gx_r  <= gx_nxt;
    gy_r  <= gy_nxt;
    sh_r  <= sh_nxt;
    qn_r  <= qn_nxt;
  end

  assign busy      = (state_r != rau_pkg::S_IDLE);
  assign out_valid = valid_r;
  assign out_res   = res_r;
endmodule
`default_nettype wire

// ===== rtl/core/rau_checker.sv =====
// rau_checker: port-level checks for rational_arith_unit_core
// depends on rau_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none
module rau_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire rau_pkg::out_res_t out_res
);
  // accepted request makes the unit busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after request");

  // a result strobe is a single cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // unit goes idle as the result appears
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy during result");

  // no result without prior busy phase
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");

  // status only alongside a compare field of zero (CMP_LESS)
  a_status_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status |-> out_res.cmp_code == rau_pkg::CMP_LESS)
    else $error("status with compare code");
endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for rational_arith_unit_core, random and directed requests
// depends on rau_pkg and rational_arith_unit_core
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  rau_pkg::in_req_t  in_req;
  logic              out_valid;
  rau_pkg::out_res_t out_res;

  rau_pkg::in_req_t  pending_reqs[$];
  rau_pkg::out_res_t expected_results[$];
  int       error_count;
  int       idle_pct;
  int       idle_cycles;
  bit       stim_done;

  rational_arith_unit_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // euclid on magnitudes
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // predicted result of one request
  function automatic rau_pkg::out_res_t rational_result(rau_pkg::in_req_t r);
    rau_pkg::out_res_t  o;
    logic signed [63:0] l;
    logic signed [63:0] rr;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] g;
    logic [31:0] qn;
    o = '0;
    case (rau_pkg::func_t'(r.func))
      rau_pkg::FN_ADD: begin
        o.res_num = r.a_num * r.b_den + r.a_den * r.b_num;
        o.res_den = r.a_den * r.b_den;
      end
      rau_pkg::FN_SUB: begin
        o.res_num = r.a_num * r.b_den - r.a_den * r.b_num;
        o.res_den = r.a_den * r.b_den;
      end
      rau_pkg::FN_MUL: begin
        o.res_num = r.a_num * r.b_num;
        o.res_den = r.a_den * r.b_den;
      end
      rau_pkg::FN_DIV: begin
        o.res_num = r.a_num * r.b_den;
        o.res_den = r.a_den * r.b_num;
      end
      rau_pkg::FN_NEG: begin
        o.res_num = -r.a_num;
        o.res_den = r.a_den;
      end
      rau_pkg::FN_CMP: begin
        l  = 64'(r.a_num) * 64'(r.b_den);
        rr = 64'(r.a_den) * 64'(r.b_num);
        if (l < rr) begin
          o.cmp_code = rau_pkg::CMP_LESS;
        end else if (l == rr) begin
          o.cmp_code = rau_pkg::CMP_EQUAL;
        end else begin
          o.cmp_code = rau_pkg::CMP_GREATER;
        end
      end
      rau_pkg::FN_NORM: begin
        if (r.a_den == 0) begin
          o.res_num = r.a_num;
          o.res_den = r.a_den;
          o.status  = rau_pkg::ST_ZERO_DEN;
        end else if (r.a_num == 0) begin
          o.res_num = 0;
          o.res_den = 1;
        end else begin
          n  = r.a_num < 0 ? -64'(r.a_num) : 64'(r.a_num);
          d  = r.a_den < 0 ? -64'(r.a_den) : 64'(r.a_den);
          g  = gcd64(n, d);
          qn = 32'(n / g);
          o.res_num = ((r.a_num < 0) != (r.a_den < 0)) ? -qn : qn;
          o.res_den = 32'(d / g);
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // operand with a bias toward edge values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 16)) - 8);
      3: return 32'h0;
      4, 5: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    rau_pkg::in_req_t r;
    r.func = f;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    pending_reqs.push_back(r);
  endtask

  // driver: hold request until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(rational_result(in_req));
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_reqs.size() != 0 &&
                 $urandom_range(0, 99) >= idle_pct) begin
      in_req <= pending_reqs.pop_front();
      start  <= 1'b1;
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    rau_pkg::out_res_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_res.res_num !== e.res_num) begin
          $error("res_num exp %h got %h", e.res_num, out_res.res_num);
          error_count++;
        end
        if (out_res.res_den !== e.res_den) begin
          $error("res_den exp %h got %h", e.res_den, out_res.res_den);
          error_count++;
        end
        if (out_res.cmp_code !== e.cmp_code) begin
          $error("cmp_code exp %h got %h", e.cmp_code, out_res.cmp_code);
          error_count++;
        end
        if (out_res.status !== e.status) begin
          $error("status exp %h got %h", e.status, out_res.status);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (!stim_done || expected_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL rational_arith_unit_core");
        $finish;
      end
    end
  end

  initial begin
    int f;
    error_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    idle_pct = 18;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every func, edges, normalize corners
    for (f = 0; f < 8; f++) begin
      push_req(3'(f), 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
      push_req(3'(f), 32'd6, 32'hffff_fff7, 32'd3, 32'd0);
    end
    push_req(rau_pkg::FN_NORM, 32'd0, 32'd5, 32'd0, 32'd0);
    push_req(rau_pkg::FN_NORM, 32'd7, 32'd0, 32'd0, 32'd0);
    push_req(rau_pkg::FN_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
    push_req(rau_pkg::FN_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    push_req(rau_pkg::FN_NORM, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
    push_req(rau_pkg::FN_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    push_req(rau_pkg::FN_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
    push_req(rau_pkg::FN_DIV, 32'd1, 32'd3, 32'd0, 32'd2);

    // random in three idle phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 580; i++) begin
        push_req($urandom_range(0, 99) < 3 ? rau_pkg::FN_NOP : 3'($urandom_range(0, 6)),
                 rand_operand(), rand_operand(), rand_operand(), rand_operand());
      end
      idle_pct = (ph == 0) ? 18 : ((ph == 1) ? 53 : 0);
      while (pending_reqs.size() != 0) @(posedge clk);
    end
    @(posedge clk);
    while (start) @(posedge clk);
    stim_done = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS rational_arith_unit_core");
    end else begin
      $display("FAIL rational_arith_unit_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_div.sv
rtl/core/rational_arith_unit_core.sv
rtl/core/rau_checker.sv
tb/tb_top.sv
